### hw/rtl/sine_cosine_polynomial_unit_top_macros.svh
// Assertion macros for the sine/cosine polynomial unit.
`ifndef SINE_COSINE_POLYNOMIAL_UNIT_TOP_MACROS_SVH
`define SINE_COSINE_POLYNOMIAL_UNIT_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SCPU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scpu assertion failed");

// next-cycle implication
`define SCPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scpu assertion failed");

`else

`define SCPU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SCPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/scpu_pkg.sv
// Shared types, constants and pipeline timing for the sine/cosine polynomial unit.
package scpu_pkg;

    localparam int ANGLE_WIDTH  = 32;
    localparam int RESULT_WIDTH = 32;
    localparam int RES_FRAC     = RESULT_WIDTH - 2;

    // working angle: Q42 in 48 bits
    localparam int XW          = 48;
    localparam int ANGLE_SHIFT = XW - ANGLE_WIDTH;

    // multiplier operand and product widths
    localparam int MW   = 64;
    localparam int HW   = MW / 2;
    localparam int PW   = 2 * MW;
    localparam int SH_W = 7;

    typedef logic signed [XW-1:0] angle_q_t;
    typedef logic signed [MW-1:0] word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam logic [XW-1:0] PI_Q42      = 48'h0C90_FDAA_2217;
    localparam logic [XW-1:0] HALF_PI_Q42 = 48'h0648_7ED5_110B;

    localparam int DIV_STEPS    = 4;
    localparam int FRONT_STAGES = DIV_STEPS + 3;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // group A in Q40, group B in Q64
    localparam word_t COEF_A [4] = '{
        64'sd1099511627776, -64'sd183251937963, 64'sd9162596898, -64'sd218157069
    };
    localparam word_t COEF_B [4] = '{
        64'sd50834275696409, -64'sd462125089543, 64'sd2960203609, -64'sd13585270
    };

    localparam logic [SH_W-1:0] SH_X2  = 7'd54;
    localparam logic [SH_W-1:0] SH_Q30 = 7'd30;
    localparam logic [SH_W-1:0] SH_X8  = 7'd40;
    localparam logic [SH_W-1:0] SH_A   = 7'd10;
    localparam logic [SH_W-1:0] SH_BX  = 7'd54;
    localparam logic [SH_W-1:0] SH_F   = SH_W'(72 - RES_FRAC);

    localparam word_t RES_ONE = 64'sd1 <<< RES_FRAC;
    localparam logic signed [RESULT_WIDTH-1:0] OUT_ONE =
        {2'b01, {RES_FRAC{1'b0}}};
    localparam logic signed [RESULT_WIDTH-1:0] OUT_MINUS_ONE = -OUT_ONE;

    // back-end timing, in cycles after the operand register
    localparam int MUL_LAT = 5;
    localparam int T_X2    = MUL_LAT;
    localparam int T_X8    = 3 * MUL_LAT;
    localparam int T_A1    = 2 * MUL_LAT + 1;
    localparam int T_A2    = 3 * MUL_LAT + 2;
    localparam int T_A3    = 4 * MUL_LAT + 3;
    localparam int T_S     = 5 * MUL_LAT + 4;
    localparam int T_F     = 6 * MUL_LAT + 4;

    localparam int X2_DLY  = T_A2 - T_X2;
    localparam int X2_TAP1 = T_A1 - T_X2 - 1;
    localparam int X2_TAP2 = T_A2 - T_X2 - 1;
    localparam int X8_DLY  = T_A3 - T_X8;
    localparam int X8_TAP  = T_A3 - T_X8 - 1;
    localparam int X_DLY   = T_S + 1;

endpackage

### hw/rtl/scpu_mul.sv
// Five-stage signed multiplier with rounded, saturated right shift.
module scpu_mul (
    input  logic                          clk,
    input  logic                          en,
    input  scpu_pkg::word_t               a,
    input  scpu_pkg::word_t               b,
    input  logic [scpu_pkg::SH_W-1:0]     shamt,
    output scpu_pkg::word_t               p
);

    logic [scpu_pkg::MW-1:0] ua_reg, ub_reg, ua_next, ub_next;
    logic [3:0]              neg_reg;
    logic                    neg_next;
    logic [scpu_pkg::MW-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [scpu_pkg::MW-1:0] p00_next, p01_next, p10_next, p11_next;
    logic [scpu_pkg::MW:0]   mid_reg, mid_next;
    logic [scpu_pkg::PW-1:0] hilo_reg, hilo_next;
    logic [scpu_pkg::PW-1:0] full_reg, full_next, rnd, mag;
    logic [scpu_pkg::MW-1:0] m;
    logic                    sat;
    scpu_pkg::word_t         p_reg, p_next;

    always_comb
    begin
        neg_next = a[scpu_pkg::MW-1] ^ b[scpu_pkg::MW-1];
        ua_next  = a[scpu_pkg::MW-1] ? $unsigned(-a) : $unsigned(a);
        ub_next  = b[scpu_pkg::MW-1] ? $unsigned(-b) : $unsigned(b);
    end

    always_comb
    begin
        p00_next = {{scpu_pkg::HW{1'b0}}, ua_reg[scpu_pkg::HW-1:0]}
                 * {{scpu_pkg::HW{1'b0}}, ub_reg[scpu_pkg::HW-1:0]};
        p01_next = {{scpu_pkg::HW{1'b0}}, ua_reg[scpu_pkg::HW-1:0]}
                 * {{scpu_pkg::HW{1'b0}}, ub_reg[scpu_pkg::MW-1:scpu_pkg::HW]};
        p10_next = {{scpu_pkg::HW{1'b0}}, ua_reg[scpu_pkg::MW-1:scpu_pkg::HW]}
                 * {{scpu_pkg::HW{1'b0}}, ub_reg[scpu_pkg::HW-1:0]};
        p11_next = {{scpu_pkg::HW{1'b0}}, ua_reg[scpu_pkg::MW-1:scpu_pkg::HW]}
                 * {{scpu_pkg::HW{1'b0}}, ub_reg[scpu_pkg::MW-1:scpu_pkg::HW]};
    end

    // outer partial products ride along with the middle sum
    always_comb
    begin
        mid_next  = {1'b0, p01_reg} + {1'b0, p10_reg};
        hilo_next = {p11_reg, p00_reg};
    end

    // round half away from zero on the magnitude
    always_comb
    begin
        rnd       = {{(scpu_pkg::PW-1){1'b0}}, 1'b1} << (shamt - 1'b1);
        full_next = hilo_reg
                  + ({{(scpu_pkg::PW-scpu_pkg::MW-1){1'b0}}, mid_reg} << scpu_pkg::HW)
                  + rnd;
    end

    always_comb
    begin
        mag    = full_reg >> shamt;
        sat    = |mag[scpu_pkg::PW-1:scpu_pkg::MW-1];
        m      = sat ? {1'b0, {(scpu_pkg::MW-1){1'b1}}}
                     : {1'b0, mag[scpu_pkg::MW-2:0]};
        p_next = neg_reg[3] ? $signed(-m) : $signed(m);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg   <= ua_next;
            ub_reg   <= ub_next;
            neg_reg  <= {neg_reg[2:0], neg_next};
            p00_reg  <= p00_next;
            p01_reg  <= p01_next;
            p10_reg  <= p10_next;
            p11_reg  <= p11_next;
            mid_reg  <= mid_next;
            hilo_reg <= hilo_next;
            full_reg <= full_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

### hw/rtl/scpu_queue.sv
// Short register queue between the classifying front end and the polynomial back end.
module scpu_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  scpu_pkg::angle_q_t        push_data,
    input  logic                      pop,
    output scpu_pkg::angle_q_t        pop_data,
    output scpu_pkg::q_status_t       status
);

    scpu_pkg::angle_q_t          mem_reg [scpu_pkg::Q_DEPTH];
    logic [scpu_pkg::Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [scpu_pkg::Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [scpu_pkg::Q_AW:0]     cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == (scpu_pkg::Q_AW+1)'(scpu_pkg::Q_DEPTH));
    assign status.empty = (cnt_reg == '0);

endmodule

### hw/rtl/scpu_front.sv
// Front end: input transfer, angle scaling and cosine range reduction by pi.
module scpu_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   req_type,
    input  logic signed [scpu_pkg::ANGLE_WIDTH-1:0] angle,
    input  scpu_pkg::q_status_t                    q_status,
    output logic                                   push,
    output scpu_pkg::angle_q_t                     push_data
);

    localparam int LAST = scpu_pkg::FRONT_STAGES - 1;

    logic [LAST:0]             vld_reg, vld_next;
    logic                      req_reg [LAST];
    scpu_pkg::angle_q_t        x_reg [LAST];
    scpu_pkg::angle_q_t        x0_next;
    logic [scpu_pkg::XW-1:0]   r_reg [scpu_pkg::DIV_STEPS+1];
    logic [scpu_pkg::XW-1:0]   r_next [scpu_pkg::DIV_STEPS+1];
    logic                      par_reg, par_next;
    scpu_pkg::angle_q_t        f_reg, f_next;
    logic                      en;

    assign en       = !vld_reg[LAST] || !q_status.full;
    assign in_ready = en;
    assign push     = vld_reg[LAST] && !q_status.full;
    assign push_data = f_reg;

    assign vld_next = {vld_reg[LAST-1:0], in_valid};
    assign x0_next  = scpu_pkg::angle_q_t'(angle) <<< scpu_pkg::ANGLE_SHIFT;

    // |x| then restoring division by pi, one quotient bit per stage
    always_comb
    begin
        logic [scpu_pkg::XW-1:0] dv;
        logic                    ge;
        dv        = '0;
        ge        = 1'b0;
        r_next[0] = x_reg[0][scpu_pkg::XW-1] ? $unsigned(-x_reg[0]) : $unsigned(x_reg[0]);
        for (int j = 1; j <= scpu_pkg::DIV_STEPS; j++)
        begin
            dv        = scpu_pkg::PI_Q42 << (scpu_pkg::DIV_STEPS - j);
            ge        = (r_reg[j-1] >= dv);
            r_next[j] = ge ? r_reg[j-1] - dv : r_reg[j-1];
        end
        par_next = ge;
    end

    // with req_type set, f = |rem| - pi/2, negated for an even quotient; else x passes on
    always_comb
    begin
        scpu_pkg::angle_q_t rs;
        scpu_pkg::angle_q_t hp;
        rs = $signed(r_reg[scpu_pkg::DIV_STEPS]);
        hp = $signed(scpu_pkg::HALF_PI_Q42);
        if (req_reg[LAST-1])
        begin
            f_next = par_reg ? rs - hp : hp - rs;
        end
        else
        begin
            f_next = x_reg[LAST-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            req_reg[0] <= req_type;
            x_reg[0]   <= x0_next;
            for (int i = 1; i < LAST; i++)
            begin
                req_reg[i] <= req_reg[i-1];
                x_reg[i]   <= x_reg[i-1];
            end
            r_reg   <= r_next;
            par_reg <= par_next;
            f_reg   <= f_next;
        end
    end

endmodule

### hw/rtl/scpu_back.sv
// Back end: degree-15 odd polynomial in two Horner groups, clamp and output register.
module scpu_back (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  scpu_pkg::q_status_t                       q_status,
    input  scpu_pkg::angle_q_t                        pop_data,
    output logic                                      pop,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [scpu_pkg::RESULT_WIDTH-1:0]  value,
    output logic                                      saturated
);

    logic [scpu_pkg::T_F:0]  vld_reg, vld_next;
    scpu_pkg::angle_q_t      x_d_reg [scpu_pkg::X_DLY];
    scpu_pkg::word_t         x2_d_reg [scpu_pkg::X2_DLY];
    scpu_pkg::word_t         x8_d_reg [scpu_pkg::X8_DLY];
    scpu_pkg::word_t         ta_reg [3];
    scpu_pkg::word_t         tb_reg [3];
    scpu_pkg::word_t         s_reg;
    scpu_pkg::word_t         x_in, x_fin;
    scpu_pkg::word_t         x2, x4, x8, ma1, ma2, ma3, mb1, mb2, mb3, mar, mbx, mf;
    logic                    out_valid_reg;
    logic signed [scpu_pkg::RESULT_WIDTH-1:0] value_reg, value_next;
    logic                    sat_reg, sat_next;
    logic                    en;

    assign en       = !out_valid_reg || out_ready;
    assign pop      = en && !q_status.empty;
    assign vld_next = {vld_reg[scpu_pkg::T_F-1:0], !q_status.empty};

    assign x_in  = scpu_pkg::word_t'(x_d_reg[0]);
    assign x_fin = scpu_pkg::word_t'(x_d_reg[scpu_pkg::T_S]);

    scpu_mul u_mul_x2 (.clk(clk), .en(en), .a(x_in), .b(x_in),
                       .shamt(scpu_pkg::SH_X2), .p(x2));
    scpu_mul u_mul_x4 (.clk(clk), .en(en), .a(x2), .b(x2),
                       .shamt(scpu_pkg::SH_Q30), .p(x4));
    scpu_mul u_mul_x8 (.clk(clk), .en(en), .a(x4), .b(x4),
                       .shamt(scpu_pkg::SH_X8), .p(x8));

    scpu_mul u_mul_a1 (.clk(clk), .en(en), .a(x2), .b(scpu_pkg::COEF_A[3]),
                       .shamt(scpu_pkg::SH_Q30), .p(ma1));
    scpu_mul u_mul_a2 (.clk(clk), .en(en), .a(x2_d_reg[scpu_pkg::X2_TAP1]), .b(ta_reg[0]),
                       .shamt(scpu_pkg::SH_Q30), .p(ma2));
    scpu_mul u_mul_a3 (.clk(clk), .en(en), .a(x2_d_reg[scpu_pkg::X2_TAP2]), .b(ta_reg[1]),
                       .shamt(scpu_pkg::SH_Q30), .p(ma3));

    scpu_mul u_mul_b1 (.clk(clk), .en(en), .a(x2), .b(scpu_pkg::COEF_B[3]),
                       .shamt(scpu_pkg::SH_Q30), .p(mb1));
    scpu_mul u_mul_b2 (.clk(clk), .en(en), .a(x2_d_reg[scpu_pkg::X2_TAP1]), .b(tb_reg[0]),
                       .shamt(scpu_pkg::SH_Q30), .p(mb2));
    scpu_mul u_mul_b3 (.clk(clk), .en(en), .a(x2_d_reg[scpu_pkg::X2_TAP2]), .b(tb_reg[1]),
                       .shamt(scpu_pkg::SH_Q30), .p(mb3));

    // group A from Q40 down to Q30
    scpu_mul u_mul_ar (.clk(clk), .en(en), .a(ta_reg[2]), .b(64'sd1),
                       .shamt(scpu_pkg::SH_A), .p(mar));
    scpu_mul u_mul_bx (.clk(clk), .en(en), .a(x8_d_reg[scpu_pkg::X8_TAP]), .b(tb_reg[2]),
                       .shamt(scpu_pkg::SH_BX), .p(mbx));
    scpu_mul u_mul_f  (.clk(clk), .en(en), .a(x_fin), .b(s_reg),
                       .shamt(scpu_pkg::SH_F), .p(mf));

    always_comb
    begin
        value_next = mf[scpu_pkg::RESULT_WIDTH-1:0];
        sat_next   = 1'b0;
        if (mf > scpu_pkg::RES_ONE)
        begin
            value_next = scpu_pkg::OUT_ONE;
            sat_next   = 1'b1;
        end
        else if (mf < -scpu_pkg::RES_ONE)
        begin
            value_next = scpu_pkg::OUT_MINUS_ONE;
            sat_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= vld_reg[scpu_pkg::T_F];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_d_reg[0] <= pop_data;
            for (int i = 1; i < scpu_pkg::X_DLY; i++)
            begin
                x_d_reg[i] <= x_d_reg[i-1];
            end
            x2_d_reg[0] <= x2;
            for (int i = 1; i < scpu_pkg::X2_DLY; i++)
            begin
                x2_d_reg[i] <= x2_d_reg[i-1];
            end
            x8_d_reg[0] <= x8;
            for (int i = 1; i < scpu_pkg::X8_DLY; i++)
            begin
                x8_d_reg[i] <= x8_d_reg[i-1];
            end
            ta_reg[0] <= scpu_pkg::COEF_A[2] + ma1;
            ta_reg[1] <= scpu_pkg::COEF_A[1] + ma2;
            ta_reg[2] <= scpu_pkg::COEF_A[0] + ma3;
            tb_reg[0] <= scpu_pkg::COEF_B[2] + mb1;
            tb_reg[1] <= scpu_pkg::COEF_B[1] + mb2;
            tb_reg[2] <= scpu_pkg::COEF_B[0] + mb3;
            s_reg     <= mar + mbx;
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign saturated = sat_reg;

endmodule

### hw/rtl/sine_cosine_polynomial_unit_top.sv
// Sine/cosine polynomial unit: front end, transfer queue and polynomial back end.
// Pipeline from input transfer to result: 7 front stages, the queue storage register,
//   then the back-end stages set by the chain of split multipliers.
// Throughput: one transfer per cycle on each side; a full output register stalls the
//   back end, a full queue stalls the front end and drops in_ready.
// Reset clears valid bits, queue pointers and the queue count only; no clearing pass.
`include "sine_cosine_polynomial_unit_top_macros.svh"

module sine_cosine_polynomial_unit_top (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      req_type,
    input  logic signed [scpu_pkg::ANGLE_WIDTH-1:0]   angle,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [scpu_pkg::RESULT_WIDTH-1:0]  value,
    output logic                                      saturated
);

    scpu_pkg::q_status_t  q_stat;
    logic                 q_push, q_pop;
    scpu_pkg::angle_q_t   q_push_data, q_pop_data;

    scpu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .angle     (angle),
        .q_status  (q_stat),
        .push      (q_push),
        .push_data (q_push_data)
    );

    scpu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_stat)
    );

    scpu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_stat),
        .pop_data  (q_pop_data),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .saturated (saturated)
    );

    `SCPU_ASSERT_IMPL(a_push_not_full, clk, rst_n, q_push, !q_stat.full)
    `SCPU_ASSERT_IMPL(a_pop_not_empty, clk, rst_n, q_pop, !q_stat.empty)
    `SCPU_ASSERT_NEXT(a_push_fills, clk, rst_n, q_push, !q_stat.empty)
    `SCPU_ASSERT_IMPL(a_sat_clamped, clk, rst_n, out_valid && saturated, value == scpu_pkg::OUT_ONE || value == scpu_pkg::OUT_MINUS_ONE)

endmodule
